// File: src/fqsm_pkg.sv
// fqsm_pkg: shared constants, codes and types of the queue with search and min/max
// used by fqsm_mem, fqsm_scan and fifo_queue_search_minmax_core
package fqsm_pkg;

	// default number of queue slots
	localparam int QUEUE_DEPTH_DEF = 16;

	// fixed field widths
	localparam int VAL_W    = 64;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 4;
	localparam int COUNT_W  = 5;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

	// control from the sequencer to the compare unit
	typedef struct packed {
		logic clr;  // clear all accumulators for a new item
		logic vld;  // an entry is on the read data bus this cycle
		logic rem;  // that entry is the removed head
	} scan_ctl_t;

endpackage

// File: src/fqsm_mem.sv
// fqsm_mem: entry storage of the queue, one write port and one registered read port
// depends on fqsm_pkg for the value width
module fqsm_mem #(
	parameter int DEPTH = fqsm_pkg::QUEUE_DEPTH_DEF,
	parameter int IW    = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [IW-1:0]                 waddr,
	input  logic [fqsm_pkg::VAL_W-1:0]    wdata,
	input  logic                          re,
	input  logic [IW-1:0]                 raddr,
	output logic [fqsm_pkg::VAL_W-1:0]    rdata
);

	logic [fqsm_pkg::VAL_W-1:0] mem [DEPTH];
	logic [fqsm_pkg::VAL_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/fqsm_scan.sv
// fqsm_scan: shared compare unit, one entry per cycle: first match, max, min, removed head
// depends on fqsm_pkg for the value width and the scan control struct
module fqsm_scan #(
	parameter int CW = fqsm_pkg::COUNT_W
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fqsm_pkg::scan_ctl_t               ctl,
	input  logic signed [fqsm_pkg::VAL_W-1:0] data,
	input  logic signed [fqsm_pkg::VAL_W-1:0] key,
	output logic                              found,
	output logic [CW-1:0]                     pos,
	output logic signed [fqsm_pkg::VAL_W-1:0] largest,
	output logic signed [fqsm_pkg::VAL_W-1:0] smallest,
	output logic signed [fqsm_pkg::VAL_W-1:0] removed
);

	logic                              have_q;
	logic                              found_q;
	logic [CW-1:0]                     idx_q;
	logic [CW-1:0]                     pos_q;
	logic signed [fqsm_pkg::VAL_W-1:0] max_q;
	logic signed [fqsm_pkg::VAL_W-1:0] min_q;
	logic signed [fqsm_pkg::VAL_W-1:0] removed_q;

	// flags and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q  <= 1'b0;
			found_q <= 1'b0;
			idx_q   <= '0;
			pos_q   <= '0;
		end else if (ctl.clr) begin
			have_q  <= 1'b0;
			found_q <= 1'b0;
			idx_q   <= '0;
			pos_q   <= '0;
		end else if (ctl.vld && !ctl.rem) begin
			have_q <= 1'b1;
			idx_q  <= idx_q + 1'b1;
			// keep only the match nearest the head
			if (!found_q && data == key) begin
				found_q <= 1'b1;
				pos_q   <= idx_q;
			end
		end
	end

	// running maximum, minimum and removed head value
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			removed_q <= '0;
		end else if (ctl.vld && ctl.rem) begin
			removed_q <= data;
		end else if (ctl.vld) begin
			if (!have_q || data > max_q) begin
				max_q <= data;
			end
			if (!have_q || data < min_q) begin
				min_q <= data;
			end
		end
	end

	assign found    = found_q;
	assign pos      = pos_q;
	assign largest  = have_q ? max_q : '0;
	assign smallest = have_q ? min_q : '0;
	assign removed  = removed_q;

endmodule

// File: src/fifo_queue_search_minmax_core.sv
// fifo_queue_search_minmax_core: ring-buffer queue with search and min/max, top level
// depends on fqsm_pkg, fqsm_mem and fqsm_scan
//
// Usage:
//   Input channel (in_valid, in_stall, op, value) carries one item: insert value at
//   the tail, remove the head, search for value, or clear the queue.
//   Output channel (out_valid, out_stall and the result fields) returns exactly one
//   result item per input item, in order.
//   Each item is scanned entry by entry in S_SCAN, then passes S_DRAIN and S_DONE;
//   the entries read are the entry count before the step for a remove, after it
//   otherwise, and the next item can be accepted from the cycle after the result
//   is loaded. The scan pace is set by the single read port of the entry memory
//   feeding the shared compare unit one entry per cycle.
//   in_stall is high while an item is in work; one item is in flight at a time.
//   A finished result sits in the output register; the next item can be accepted
//   while it waits. If the receiver still stalls when the following result is
//   ready, the sequencer holds that result and keeps in_stall high.
//   Reset empties the queue (head, tail, count zero) and drops any pending result;
//   entry contents are not cleared since only occupied slots are ever read.
module fifo_queue_search_minmax_core #(
	parameter int QUEUE_DEPTH = fqsm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic [fqsm_pkg::OP_W-1:0]               op,
	input  logic signed [fqsm_pkg::VAL_W-1:0]       value,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [fqsm_pkg::STATUS_W-1:0]           status,
	output logic signed [fqsm_pkg::VAL_W-1:0]       removed_value,
	output logic                                    found,
	output logic [fqsm_pkg::POS_W-1:0]              position,
	output logic [fqsm_pkg::COUNT_W-1:0]            entry_count,
	output logic signed [fqsm_pkg::VAL_W-1:0]       largest,
	output logic signed [fqsm_pkg::VAL_W-1:0]       smallest
);

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

	// sequencer states
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0]                              state_q;
	logic [IW-1:0]                           head_q;
	logic [IW-1:0]                           tail_q;
	logic [CW-1:0]                           count_q;
	logic [IW-1:0]                           rd_addr_q;
	logic [CW-1:0]                           left_q;
	logic                                    rem_pend_q;
	logic                                    srch_q;
	logic [fqsm_pkg::STATUS_W-1:0]           stat_q;
	logic signed [fqsm_pkg::VAL_W-1:0]       key_q;
	logic                                    clr_q;
	logic                                    rd_vld_s1;
	logic                                    rd_rem_s1;

	logic                                    out_valid_q;
	logic [fqsm_pkg::STATUS_W-1:0]           status_q;
	logic signed [fqsm_pkg::VAL_W-1:0]       removed_q;
	logic                                    found_q;
	logic [fqsm_pkg::POS_W-1:0]              position_q;
	logic [fqsm_pkg::COUNT_W-1:0]            count_out_q;
	logic signed [fqsm_pkg::VAL_W-1:0]       largest_q;
	logic signed [fqsm_pkg::VAL_W-1:0]       smallest_q;

	logic                                    accept;
	logic                                    wr_en;
	logic                                    rd_en;
	logic                                    load_out;
	logic [IW-1:0]                           head_nxt;
	logic [IW-1:0]                           tail_nxt;
	logic [IW-1:0]                           rd_addr_nxt;
	logic [fqsm_pkg::VAL_W-1:0]              rd_data;
	fqsm_pkg::scan_ctl_t                     scan_ctl;
	logic                                    sc_found;
	logic [CW-1:0]                           sc_pos;
	logic signed [fqsm_pkg::VAL_W-1:0]       sc_max;
	logic signed [fqsm_pkg::VAL_W-1:0]       sc_min;
	logic signed [fqsm_pkg::VAL_W-1:0]       sc_removed;

	// handshake and ring index arithmetic
	assign in_stall    = (state_q != S_IDLE);
	assign accept      = in_valid && !in_stall;
	assign head_nxt    = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign tail_nxt    = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
	assign rd_addr_nxt = (rd_addr_q == LAST_IDX) ? '0 : rd_addr_q + 1'b1;
	assign wr_en       = accept && (op == fqsm_pkg::OP_INSERT) && (count_q != FULL_CNT);
	assign rd_en       = (state_q == S_SCAN) && (left_q != '0);
	assign load_out    = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	fqsm_mem #(
		.DEPTH (QUEUE_DEPTH),
		.IW    (IW)
	) u_mem (
		.clk   (clk),
		.we    (wr_en),
		.waddr (tail_q),
		.wdata (value),
		.re    (rd_en),
		.raddr (rd_addr_q),
		.rdata (rd_data)
	);

	assign scan_ctl.clr = clr_q;
	assign scan_ctl.vld = rd_vld_s1;
	assign scan_ctl.rem = rd_rem_s1;

	fqsm_scan #(
		.CW (CW)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.data     (rd_data),
		.key      (key_q),
		.found    (sc_found),
		.pos      (sc_pos),
		.largest  (sc_max),
		.smallest (sc_min),
		.removed  (sc_removed)
	);

	// sequencer, queue pointers and read issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			rd_addr_q  <= '0;
			left_q     <= '0;
			rem_pend_q <= 1'b0;
			srch_q     <= 1'b0;
			stat_q     <= fqsm_pkg::ST_OK;
			clr_q      <= 1'b0;
			rd_vld_s1  <= 1'b0;
			rd_rem_s1  <= 1'b0;
		end else begin
			clr_q     <= accept;
			rd_vld_s1 <= rd_en;
			rd_rem_s1 <= rd_en && rem_pend_q;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_addr_q  <= head_q;
						rem_pend_q <= 1'b0;
						srch_q     <= 1'b0;
						stat_q     <= fqsm_pkg::ST_OK;
						state_q    <= S_SCAN;
						case (op)
							fqsm_pkg::OP_INSERT: begin
								if (count_q == FULL_CNT) begin
									stat_q <= fqsm_pkg::ST_FULL;
									left_q <= count_q;
								end else begin
									tail_q  <= tail_nxt;
									count_q <= count_q + 1'b1;
									left_q  <= count_q + 1'b1;
								end
							end
							fqsm_pkg::OP_REMOVE: begin
								left_q <= count_q;
								if (count_q == '0) begin
									stat_q <= fqsm_pkg::ST_EMPTY;
								end else begin
									head_q     <= head_nxt;
									count_q    <= count_q - 1'b1;
									rem_pend_q <= 1'b1;
								end
							end
							fqsm_pkg::OP_SEARCH: begin
								left_q <= count_q;
								if (count_q == '0) begin
									stat_q <= fqsm_pkg::ST_EMPTY;
								end else begin
									srch_q <= 1'b1;
								end
							end
							default: begin
								head_q  <= '0;
								tail_q  <= '0;
								count_q <= '0;
								left_q  <= '0;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (left_q != '0) begin
						rd_addr_q  <= rd_addr_nxt;
						left_q     <= left_q - 1'b1;
						rem_pend_q <= 1'b0;
					end else begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				default: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// search key
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= value;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			if (srch_q) begin
				status_q <= sc_found ? fqsm_pkg::ST_OK : fqsm_pkg::ST_NOT_FOUND;
			end else begin
				status_q <= stat_q;
			end
			found_q     <= srch_q && sc_found;
			position_q  <= (srch_q && sc_found) ? fqsm_pkg::POS_W'(sc_pos) : '0;
			removed_q   <= sc_removed;
			count_out_q <= fqsm_pkg::COUNT_W'(count_q);
			largest_q   <= sc_max;
			smallest_q  <= sc_min;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign removed_value = removed_q;
	assign found         = found_q;
	assign position      = position_q;
	assign entry_count   = count_out_q;
	assign largest       = largest_q;
	assign smallest      = smallest_q;

`ifndef SYNTH
	// occupancy never exceeds the ring size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count exceeds depth");

	// an empty or full ring has head and tail on the same slot
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == FULL_CNT) |-> head_q == tail_q)
		else $error("head and tail disagree with count");

	// a new result only appears after the sequencer finished an item
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_DONE))
		else $error("result produced outside done state");

	// no memory read is issued for an item beyond its entries
	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> left_q <= FULL_CNT)
		else $error("scan length out of range");
`endif

endmodule
